// ===== rtl/core/apcc_pkg.sv =====
package apcc_pkg;

  typedef enum logic [2:0] {
    ELEM_C     = 3'd0,
    ELEM_O     = 3'd1,
    ELEM_N     = 3'd2,
    ELEM_H     = 3'd3,
    ELEM_OTHER = 3'd4
  } elem_e;

  typedef enum logic [1:0] {
    REG_RADII_LOW  = 2'd0,
    REG_RADII_MID  = 2'd1,
    REG_RADII_HIGH = 2'd2,
    REG_MIN_SEP    = 2'd3
  } reg_idx_e;

  localparam int unsigned RadiusW   = 16;
  localparam int unsigned NumLanes  = 10;
  localparam int unsigned LaneW     = 4;
  localparam int unsigned SepW      = 8;
  localparam int unsigned ElemW     = 3;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned ApbAddrW  = 5;

  localparam logic [63:0] RadiiLowRst  = 64'h0233_02CD_02B3_0300;
  localparam logic [63:0] RadiiMidRst  = 64'h029A_0233_029A_02B3;
  localparam logic [31:0] RadiiHighRst = 32'h01E6_0233;
  localparam logic [7:0]  MinSepRst    = 8'd3;

  // symmetric element pair -> radius lane
  localparam logic [LaneW-1:0] LaneOfPair [4][4] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3},
    '{4'd1, 4'd4, 4'd5, 4'd6},
    '{4'd2, 4'd5, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd8, 4'd9}
  };

  typedef struct packed {
    logic [31:0]     radii_high;
    logic [63:0]     radii_mid;
    logic [63:0]     radii_low;
    logic [SepW-1:0] min_sep;
  } cfg_t;

endpackage

// ===== rtl/core/atom_pair_clash_counter.sv =====
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------------
// in       | input     | in_valid_i / in_ready_o  | coords, elements, bond_separation, final
// out      | output    | out_valid_o / out_ready_i| clash, clash_total, unknown, total_done
// cfg      | input     | APB psel/penable/pready  | four registers at byte address 8*i
//
// One beat per cycle while the output is taken; a result passes the s1, s2 and output registers.
// Stages: diff/radius lookup, three coordinate squares plus radius square, then
// sum-compare and count update into the output register.
// All stages advance together when the output register is empty or being taken.
// Reset is asynchronous, active low; counter and config return to defaults.
module atom_pair_clash_counter #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      first_x_i,
  input  logic signed [COORD_BITS-1:0]      first_y_i,
  input  logic signed [COORD_BITS-1:0]      first_z_i,
  input  logic signed [COORD_BITS-1:0]      second_x_i,
  input  logic signed [COORD_BITS-1:0]      second_y_i,
  input  logic signed [COORD_BITS-1:0]      second_z_i,
  input  logic [apcc_pkg::ElemW-1:0]        first_element_i,
  input  logic [apcc_pkg::ElemW-1:0]        second_element_i,
  input  logic [apcc_pkg::SepW-1:0]         bond_separation_i,
  input  logic                              final_pair_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              clash_o,
  output logic [apcc_pkg::TotalW-1:0]       clash_total_o,
  output logic                              unknown_element_o,
  output logic                              total_done_o,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apcc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [apcc_pkg::ApbDataW-1:0]     pwdata,
  output logic [apcc_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned SqW   = 2 * DiffW;
  localparam int unsigned SumW  = (SqW + 2 > 32) ? SqW + 2 : 32;
  localparam int unsigned ExtW  = (COUNT_BITS > apcc_pkg::TotalW) ? COUNT_BITS
                                                                   : apcc_pkg::TotalW;
  localparam int unsigned TableW = apcc_pkg::NumLanes * apcc_pkg::RadiusW;

  apcc_pkg::cfg_t cfg;

  apcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic advance;
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // ---------------- stage 1: differences and radius lookup
  logic                          unknown_in, check_in;
  logic [apcc_pkg::LaneW-1:0]    lane_in;
  logic [TableW-1:0]             radii_table;
  logic [apcc_pkg::RadiusW-1:0]  radius_in;
  logic signed [DiffW-1:0]       dx_in, dy_in, dz_in;

  assign unknown_in = (first_element_i  > apcc_pkg::ElemW'(apcc_pkg::ELEM_H)) ||
                      (second_element_i > apcc_pkg::ElemW'(apcc_pkg::ELEM_H));
  assign check_in   = !unknown_in && (bond_separation_i > cfg.min_sep);
  assign lane_in    = apcc_pkg::LaneOfPair[first_element_i[1:0]][second_element_i[1:0]];
  assign radii_table = {cfg.radii_high, cfg.radii_mid, cfg.radii_low};
  assign radius_in  = radii_table[lane_in * apcc_pkg::RadiusW +: apcc_pkg::RadiusW];

  assign dx_in = DiffW'(first_x_i) - DiffW'(second_x_i);
  assign dy_in = DiffW'(first_y_i) - DiffW'(second_y_i);
  assign dz_in = DiffW'(first_z_i) - DiffW'(second_z_i);

  logic                          s1_valid_q;
  logic signed [DiffW-1:0]       s1_dx_q, s1_dy_q, s1_dz_q;
  logic [apcc_pkg::RadiusW-1:0]  s1_radius_q;
  logic                          s1_check_q, s1_unknown_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_dx_q      <= dx_in;
      s1_dy_q      <= dy_in;
      s1_dz_q      <= dz_in;
      s1_radius_q  <= radius_in;
      s1_check_q   <= check_in;
      s1_unknown_q <= unknown_in;
      s1_last_q    <= final_pair_i;
    end
  end

  // ---------------- stage 2: squares
  logic [DiffW-1:0] ax, ay, az;
  assign ax = s1_dx_q[DiffW-1] ? DiffW'(-s1_dx_q) : DiffW'(s1_dx_q);
  assign ay = s1_dy_q[DiffW-1] ? DiffW'(-s1_dy_q) : DiffW'(s1_dy_q);
  assign az = s1_dz_q[DiffW-1] ? DiffW'(-s1_dz_q) : DiffW'(s1_dz_q);

  logic              s2_valid_q;
  logic [SqW-1:0]    s2_sqx_q, s2_sqy_q, s2_sqz_q;
  logic [31:0]       s2_r2_q;
  logic              s2_check_q, s2_unknown_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_sqx_q     <= SqW'(ax) * SqW'(ax);
      s2_sqy_q     <= SqW'(ay) * SqW'(ay);
      s2_sqz_q     <= SqW'(az) * SqW'(az);
      s2_r2_q      <= 32'(s1_radius_q) * 32'(s1_radius_q);
      s2_check_q   <= s1_check_q;
      s2_unknown_q <= s1_unknown_q;
      s2_last_q    <= s1_last_q;
    end
  end

  // ---------------- stage 3: compare, count, output register
  logic [SumW-1:0]       d2_sum;
  logic                  clash_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_new;
  logic [ExtW-1:0]       cnt_ext;
  logic                  s2_take;

  assign d2_sum  = SumW'(s2_sqx_q) + SumW'(s2_sqy_q) + SumW'(s2_sqz_q);
  assign clash_d = s2_check_q && (d2_sum < SumW'(s2_r2_q));
  assign cnt_new = (clash_d && (cnt_q != {COUNT_BITS{1'b1}})) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_ext = ExtW'(cnt_new);
  assign s2_take = s2_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_o <= s2_valid_q;
      end
      if (s2_take) begin
        cnt_q <= s2_last_q ? '0 : cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      clash_o           <= clash_d;
      clash_total_o     <= cnt_ext[apcc_pkg::TotalW-1:0];
      unknown_element_o <= s2_unknown_q;
      total_done_o      <= s2_last_q;
    end
  end

  // ---------------- checks
  a_unknown_never_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_element_o |-> !clash_o)
    else $error("clash flagged on a pair with an unknown element");

  a_final_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_take && s2_last_q |=> cnt_q == '0)
    else $error("count not cleared after final pair");

  a_count_moves_on_clash_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_take && !clash_d && !s2_last_q |=> $stable(cnt_q))
    else $error("count changed without a clash");

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready out of step with output register");

endmodule

// ===== rtl/core/apcc_regs.sv =====
module apcc_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apcc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [apcc_pkg::ApbDataW-1:0]     pwdata,
  output logic [apcc_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output apcc_pkg::cfg_t                    cfg_o
);

  apcc_pkg::cfg_t     cfg_q, cfg_d;
  apcc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = apcc_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        apcc_pkg::REG_RADII_LOW:  cfg_d.radii_low  = pwdata;
        apcc_pkg::REG_RADII_MID:  cfg_d.radii_mid  = pwdata;
        apcc_pkg::REG_RADII_HIGH: cfg_d.radii_high = pwdata[31:0];
        apcc_pkg::REG_MIN_SEP:    cfg_d.min_sep    = pwdata[apcc_pkg::SepW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      apcc_pkg::REG_RADII_LOW:  prdata = cfg_q.radii_low;
      apcc_pkg::REG_RADII_MID:  prdata = cfg_q.radii_mid;
      apcc_pkg::REG_RADII_HIGH: prdata = {32'd0, cfg_q.radii_high};
      apcc_pkg::REG_MIN_SEP:    prdata = {{(apcc_pkg::ApbDataW-apcc_pkg::SepW){1'b0}},
                                          cfg_q.min_sep};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radii_low  <= apcc_pkg::RadiiLowRst;
      cfg_q.radii_mid  <= apcc_pkg::RadiiMidRst;
      cfg_q.radii_high <= apcc_pkg::RadiiHighRst;
      cfg_q.min_sep    <= apcc_pkg::MinSepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
